[src/carry_chain_prng_bounded_draw_core_defines.svh]
// Assertion macros for the carry-chain generator core.
// Included by the top level; expects clk and arst_n in scope.
`ifndef CARRY_CHAIN_PRNG_BOUNDED_DRAW_CORE_DEFINES_SVH
`define CARRY_CHAIN_PRNG_BOUNDED_DRAW_CORE_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define CCPBD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define CCPBD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/ccpbd_pkg.sv]
// Shared types, constants, the generator step function and the cover-mask function for the carry-chain core.
// No dependencies; imported by the controller, the datapath and the top level.
package ccpbd_pkg;

	typedef enum logic [1:0] {
		CMD_STEP   = 2'd0,
		CMD_DRAW   = 2'd1,
		CMD_RESEED = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_BUSY = 1'b1
	} state_t;

	typedef struct packed {
		logic [15:0] sum_word;
		logic [15:0] shift_word;
		logic [15:0] result_word;
	} gen_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic draw_ok;
		logic guard_hit;
		logic count_last;
	} stat_t;

	localparam logic [15:0] STEP_ADD_A = 16'd71;
	localparam logic [15:0] STEP_ADD_B = 16'd32111;

	// State after clearing and running two steps, the same as a reseed with zero seconds.
	localparam gen_t GEN_RESET = '{sum_word: 16'd14741, shift_word: 16'd426,
		result_word: 16'd15398};

	function automatic gen_t gen_step(input gen_t g);
		logic [16:0] t1;
		logic [16:0] t2;
		logic [15:0] u;
		logic [15:0] sh;
		logic [16:0] w;
		gen_t n;
		t1 = {1'b0, g.shift_word} + {1'b0, STEP_ADD_A};
		sh = t1[15:0];
		t2 = {1'b0, g.sum_word} + {1'b0, STEP_ADD_B} + {16'd0, t1[16]};
		u = t2[15:0] + g.result_word + {15'd0, t2[16]};
		w = {1'b0, u} + {1'b0, g.result_word} + {16'd0, sh[15]};
		n.sum_word = u;
		n.shift_word = {sh[14:0], 1'b0};
		n.result_word = {w[16], w[15:1]};
		return n;
	endfunction

	// Smallest all-ones mask that covers the argument.
	function automatic logic [15:0] cover_mask(input logic [15:0] v);
		logic [15:0] m;
		m = v;
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		return m;
	endfunction

endpackage

[src/ccpbd_ctrl.sv]
// Controller state machine for the carry-chain core: handshakes and step sequencing.
// Depends on ccpbd_pkg for the state, command and status types.
module ccpbd_ctrl import ccpbd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;
	logic   done;

	// The output slot can take a result if empty or being drained this cycle.
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		unique case (stat.cmd)
			CMD_STEP:   done = 1'b1;
			CMD_DRAW:   done = stat.draw_ok || stat.guard_hit;
			CMD_RESEED: done = stat.count_last;
			CMD_NONE:   done = 1'b1;
			default:    done = 1'b1;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_BUSY;
			end
			ST_BUSY: begin
				if (slot_free && done) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctrl.load = in_valid;
			end
			ST_BUSY: begin
				ctrl.step = slot_free && (stat.cmd != CMD_NONE);
				ctrl.finish = slot_free && done;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[src/ccpbd_dp.sv]
// Datapath for the carry-chain core: generator words, draw mask, counters and result.
// Depends on ccpbd_pkg for the step function, mask function and shared types.
module ccpbd_dp import ccpbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctrl,
	input  logic [1:0]  command,
	input  logic [15:0] limit,
	input  logic [7:0]  seconds,
	output stat_t       stat,
	output logic [15:0] value
);

	gen_t        gen_q;
	gen_t        gen_next;
	cmd_t        cmd_q;
	logic [15:0] limit_q;
	logic [15:0] mask_q;
	logic [16:0] count_q;
	logic [16:0] tries_q;
	logic [15:0] value_q;
	logic [15:0] masked;
	logic [15:0] result;
	logic [8:0]  secs_a;
	logic [8:0]  secs_b;
	logic [17:0] steps;

	assign gen_next = gen_step(gen_q);
	assign masked = gen_next.result_word & mask_q;

	// Warm-up length is (seconds+1)*(seconds+2), at most 65792.
	assign secs_a = {1'b0, seconds} + 9'd1;
	assign secs_b = {1'b0, seconds} + 9'd2;
	assign steps = secs_a * secs_b;

	assign stat.cmd = cmd_q;
	assign stat.draw_ok = (masked <= limit_q);
	assign stat.guard_hit = tries_q[16];
	assign stat.count_last = (count_q == 17'd1);

	always_comb begin
		unique case (cmd_q)
			CMD_STEP:   result = gen_next.result_word;
			CMD_DRAW:   result = stat.draw_ok ? masked : (masked & (mask_q >> 1));
			CMD_RESEED: result = '0;
			CMD_NONE:   result = '0;
			default:    result = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= GEN_RESET;
		end else if (ctrl.load && (cmd_t'(command) == CMD_RESEED)) begin
			gen_q <= '0;
		end else if (ctrl.step) begin
			gen_q <= gen_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q <= cmd_t'(command);
			limit_q <= limit;
			mask_q <= cover_mask(limit);
			count_q <= steps[16:0];
			tries_q <= '0;
		end else if (ctrl.step) begin
			count_q <= count_q - 17'd1;
			tries_q <= tries_q + 17'd1;
		end
		if (ctrl.finish) value_q <= result;
	end

	assign value = value_q;

endmodule

[src/carry_chain_prng_bounded_draw_core.sv]
// A raw step makes one generator step; a bounded draw makes one step per candidate
// until one fits the limit or the guard count is hit; a reseed clears the words and
// makes (seconds+1)*(seconds+2) steps. One item is in flight at a time, and the output
// register lets the next item start while a result waits. Reset is asynchronous,
// active low, and loads the generator words with the zero-seconds reseed state.
`include "carry_chain_prng_bounded_draw_core_defines.svh"

module carry_chain_prng_bounded_draw_core import ccpbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] limit,
	input  logic [7:0]  seconds,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] value
);

	// The controller and datapath talk only through these two structs.
	ctrl_t ctrl;
	stat_t stat;
	logic  reseed_done;

	// The controller owns both handshakes. In idle it takes an input transfer and asks the
	// datapath to latch the command, limit and warm-up count. While busy it issues one
	// generator step per cycle (none for the unused command), but only while the output
	// register is free or being drained, so a result is never overwritten or stepped past.
	ccpbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	// The datapath holds the three generator words, the draw mask and limit, the
	// reseed step counter and the draw rejection counter, and the output value.
	// A draw that keeps rejecting is cut off after its guard count and returns the
	// masked word with the top mask bit cleared.
	ccpbd_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.command (command),
		.limit   (limit),
		.seconds (seconds),
		.stat    (stat),
		.value   (value)
	);

	// A reseed is finishing and its result is about to be loaded.
	assign reseed_done = ctrl.finish && (stat.cmd == CMD_RESEED);

	// Generator steps happen only while an item is in flight.
	`CCPBD_ASSERT_NOW(a_step_busy, ctrl.step, !in_ready, "generator stepped while idle")
	// An accepted transfer always leaves the block busy in the following cycle.
	`CCPBD_ASSERT_NEXT(a_accept_busy, in_valid && in_ready, !in_ready, "accept did not start work")
	// A finished item is presented on the output in the next cycle.
	`CCPBD_ASSERT_NEXT(a_finish_out, ctrl.finish, out_valid, "finished result not presented")
	// A reseed always reports zero.
	`CCPBD_ASSERT_NEXT(a_reseed_zero, reseed_done, value == 16'd0, "reseed result not zero")

endmodule

[test/carry_chain_draw_checker.sv]
// Watches both channels of the carry-chain generator core, predicts every result
// from its own copy of the generator words, and counts mismatches for the testbench top.
// Depends on ccpbd_pkg for the command codes and the step constants.
module carry_chain_draw_checker import ccpbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  command,
	input  logic [15:0] limit,
	input  logic [7:0]  seconds,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] value,
	output int          fail_count,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REJECT_CAP = 65536;

	logic [15:0] acc_word;
	logic [15:0] shf_word;
	logic [15:0] res_word;
	logic [15:0] expected_values[$];

	// One pass of the add-with-carry chain, ending in the rotate through carry.
	function automatic logic [15:0] next_word();
		logic [16:0] t;
		logic        c;
		t = {1'b0, shf_word} + {1'b0, STEP_ADD_A};
		shf_word = t[15:0];
		c = t[16];
		t = {1'b0, acc_word} + {1'b0, STEP_ADD_B} + {16'd0, c};
		t = {1'b0, t[15:0]} + {1'b0, res_word} + {16'd0, t[16]};
		acc_word = t[15:0];
		c = shf_word[15];
		shf_word = {shf_word[14:0], 1'b0};
		t = {1'b0, acc_word} + {1'b0, res_word} + {16'd0, c};
		res_word = {t[16], t[15:1]};
		return res_word;
	endfunction

	function automatic void reseed_words(input logic [7:0] secs);
		logic [15:0] unused;
		acc_word = '0;
		shf_word = '0;
		res_word = '0;
		for (int o = 0; o <= int'(secs); o++) begin
			unused = next_word();
			for (int i = 0; i <= int'(secs); i++)
				unused = next_word();
		end
	endfunction

	// Mask-and-reject draw; the cap only matters for states far from reset.
	function automatic logic [15:0] draw_within(input logic [15:0] lim);
		logic [15:0] span;
		logic [15:0] rest;
		logic [15:0] pick;
		int unsigned misses;
		span = '0;
		rest = lim;
		while (rest != 0) begin
			rest = rest >> 1;
			span = {span[14:0], 1'b1};
		end
		pick = next_word() & span;
		misses = 0;
		while (pick > lim) begin
			if (misses >= REJECT_CAP)
				return pick & (span >> 1);
			pick = next_word() & span;
			misses++;
		end
		return pick;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [15:0] want;
		if (!arst_n) begin
			reseed_words(8'd0);
			expected_values.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			// Retire the output transfer first: it can never belong to an input
			// accepted at this same edge.
			if (out_valid && out_ready) begin
				if (expected_values.size() == 0) begin
					$error("value: unexpected transfer, expected none, actual %0d", value);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_values.pop_front();
					if (value !== want) begin
						$error("value mismatch: expected %0d, actual %0d", want, value);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (cmd_t'(command))
					CMD_STEP:   want = next_word();
					CMD_DRAW:   want = draw_within(limit);
					CMD_RESEED: begin
						reseed_words(seconds);
						want = '0;
					end
					default:    want = '0;
				endcase
				expected_values.push_back(want);
			end
			outstanding <= expected_values.size();
		end
	end

endmodule

[test/carry_chain_prng_bounded_draw_core_tb.sv]
// Testbench top for the carry-chain generator core: drives commands with bursty
// timing, stalls the result channel, and gives the verdict from the checker's count.
// Depends on ccpbd_pkg, the core, and carry_chain_draw_checker.
module carry_chain_prng_bounded_draw_core_tb import ccpbd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// The limit sits well above the slowest plausible run, which is dominated by
	// the long reseeds.
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int          RANDOM_ITEMS = 1230;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  command = CMD_STEP;
	logic [15:0] limit = '0;
	logic [7:0]  seconds = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] value;

	int          fail_count;
	int          outstanding;
	int unsigned cycle_count = 0;
	int          burst_left = 0;
	int          big_reseeds_left = 2;
	int          rx_mode = 0;
	int          rx_left = 0;

	carry_chain_prng_bounded_draw_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.limit     (limit),
		.seconds   (seconds),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value     (value)
	);

	carry_chain_draw_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.limit       (limit),
		.seconds     (seconds),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.value       (value),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// The receiver switches at random between three stall patterns: always
	// ready, a coin flip per cycle, and mostly stalled. This moves the stalls
	// across every phase of the core's work.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_left = $urandom_range(20, 300);
		end
		rx_left = rx_left - 1;
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			default: out_ready <= ($urandom_range(0, 5) == 0);
		endcase
	end

	// Presents one item and returns at the edge where its transfer happens.
	// Between bursts valid drops for a random gap; within a burst the next item
	// follows the previous transfer at once, so valid is never dropped and
	// raised in the same step.
	task automatic issue(input cmd_t cmd, input logic [15:0] lim, input logic [7:0] secs);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			// Now and then a long burst gives a stretch with no idling at all.
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
		end
		burst_left = burst_left - 1;
		in_valid <= 1'b1;
		command <= cmd;
		limit <= lim;
		seconds <= secs;
		do @(posedge clk); while (!in_ready);
	endtask

	// Holds off the sender until every predicted result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Limits lean toward small values and power-of-two edges: a power of two itself
	// makes the mask reject the largest share of candidates, one less rejects none.
	function automatic logic [15:0] pick_limit();
		int k;
		k = $urandom_range(0, 15);
		case ($urandom_range(0, 4))
			0:       return 16'($urandom_range(0, 15));
			1:       return 16'(1 << k);
			2:       return 16'((1 << (k + 1)) - 1);
			default: return 16'($urandom) & 16'((1 << (k + 1)) - 1);
		endcase
	endfunction

	initial begin
		int          r;
		cmd_t        cmd;
		logic [7:0]  secs;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: edge limits, each command, a zero limit that still
		// steps once, the unused command, and the shortest and longest reseeds.
		issue(CMD_STEP, 16'h0000, 8'h00);
		issue(CMD_DRAW, 16'h0000, 8'h00);
		issue(CMD_DRAW, 16'h0001, 8'hFF);
		issue(CMD_DRAW, 16'hFFFF, 8'h00);
		issue(CMD_DRAW, 16'h8000, 8'h00);
		issue(CMD_DRAW, 16'h7FFF, 8'h00);
		issue(CMD_DRAW, 16'h5555, 8'h00);
		issue(CMD_DRAW, 16'hAAAA, 8'h00);
		issue(CMD_DRAW, 16'h0002, 8'h00);
		issue(CMD_DRAW, 16'h0003, 8'h00);
		issue(CMD_NONE, 16'hFFFF, 8'hFF);
		issue(CMD_STEP, 16'hFFFF, 8'hFF);
		issue(CMD_RESEED, 16'h0000, 8'h00);
		issue(CMD_STEP, 16'h0000, 8'h00);
		issue(CMD_DRAW, 16'd100, 8'h00);
		issue(CMD_RESEED, 16'hFFFF, 8'hFF);
		issue(CMD_STEP, 16'h0000, 8'h00);
		issue(CMD_DRAW, 16'hFFFF, 8'h00);
		issue(CMD_RESEED, 16'h0000, 8'h01);
		issue(CMD_DRAW, 16'h0007, 8'h00);
		issue(CMD_NONE, 16'h0000, 8'h00);
		issue(CMD_STEP, 16'h0000, 8'h00);
		drain();

		// Random part: mostly steps and draws, with occasional reseeds and the unused
		// command. Reseeds keep short warm-ups except for at most two long ones.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				cmd = CMD_DRAW;
			else if (r < 88)
				cmd = CMD_STEP;
			else if (r < 93)
				cmd = CMD_NONE;
			else
				cmd = CMD_RESEED;
			secs = 8'($urandom);
			if (cmd == CMD_RESEED) begin
				if (big_reseeds_left > 0 && $urandom_range(0, 39) == 0) begin
					secs = 8'($urandom_range(16, 255));
					big_reseeds_left = big_reseeds_left - 1;
				end else begin
					secs = 8'($urandom_range(0, 12));
				end
			end
			issue(cmd, pick_limit(), secs);
			if (n % 300 == 299)
				drain();
		end

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/ccpbd_pkg.sv
src/ccpbd_ctrl.sv
src/ccpbd_dp.sv
src/carry_chain_prng_bounded_draw_core.sv
test/carry_chain_draw_checker.sv
test/carry_chain_prng_bounded_draw_core_tb.sv
